FILE: hw/rtl/bstt_pkg.sv
// ----------------------------------------------------------------------------
// bstt_pkg
// shared types and codes of the bounded sorted top-k table
// ----------------------------------------------------------------------------
package bstt_pkg;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;

   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   localparam logic [7:0] MAX_ENTRIES_RESET = 8'd100;

   localparam int ENTRY_W = 64;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  index;
      logic [31:0] score;
      logic [31:0] payload;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  position;
      logic [31:0] row_score;
      logic [31:0] row_payload;
      logic [7:0]  row_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] score;
      logic [31:0] payload;
   } entry_type;

endpackage

FILE: hw/rtl/bstt_ram.sv
// ----------------------------------------------------------------------------
// bstt_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bstt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 129
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bounded_sorted_topk_table_unit.sv
// ----------------------------------------------------------------------------
// bounded_sorted_topk_table_unit
// table of score/payload entries kept in descending score order
// ----------------------------------------------------------------------------
// Entries live in one ram of DEPTH+1 rows with a registered read.
// One request beat is worked on at a time. An add trims the table to the
// limit, then scans the rows from the top, one row read per cycle, for the
// first stored score strictly below the new one, then moves the rows below
// that point down by one, a read and a write per cycle, and writes the new
// row. An add with a zero score, or whose place falls at or past the limit,
// is rejected. A read waits for the registered ram read; an overwrite writes
// its row straight from idle. The response beat sits in an output register
// and the next request beat is taken while it waits. The table resets empty
// and needs no clearing pass.
module bounded_sorted_topk_table_unit
   import bstt_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int ROWS = DEPTH + 1;
   localparam int AW   = $clog2(ROWS);
   localparam int CW   = ($clog2(DEPTH + 2) > 9) ? $clog2(DEPTH + 2) : 9;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_SHIFT  = 6'b000100,
      S_INSERT = 6'b001000,
      S_RDWAIT = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0]    max_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          chk_ff, chk_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [AW-1:0] waddr_ff, waddr_in;
   req_type       req_ff, req_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type         rd_entry;

   logic [CW-1:0] limit;
   logic [CW-1:0] trimmed;
   logic [CW-1:0] idx_c;
   logic [CW-1:0] ptr_dec;
   logic [CW-1:0] x_w;
   logic          found;
   logic          out_of_range;

   bstt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);
   assign limit    = (CW'(max_ff) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(max_ff);
   assign trimmed  = (count_ff > limit) ? limit : count_ff;
   assign idx_c    = CW'(req_data.index);
   assign ptr_dec  = ptr_ff - CW'(1);
   assign out_of_range = (idx_c >= count_ff) || (idx_c > CW'(DEPTH));

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      chk_in       = chk_ff;
      pos_in       = pos_ff;
      waddr_in     = waddr_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = waddr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ptr_ff[AW-1:0];
      found        = 1'b0;
      x_w          = ptr_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
               res_in.row_count = count_ff[7:0];
               state_in = S_FINISH;
               case (req_data.func)
                  FUNC_ADD: begin
                     count_in = trimmed;
                     res_in.row_count = trimmed[7:0];
                     if (req_data.score == 32'd0) begin
                        res_in.status = STATUS_REJECT;
                     end else begin
                        ptr_in   = '0;
                        chk_in   = 1'b0;
                        state_in = S_SEARCH;
                     end
                  end
                  FUNC_READ: begin
                     if (out_of_range) begin
                        res_in.status = STATUS_RANGE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_c[AW-1:0];
                        state_in    = S_RDWAIT;
                     end
                  end
                  FUNC_WRITE: begin
                     if (out_of_range) begin
                        res_in.status = STATUS_RANGE;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = idx_c[AW-1:0];
                        ram_wr_data = {req_data.score, req_data.payload};
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (chk_ff && (rd_entry.score < req_ff.score)) begin
               found = 1'b1;
               x_w   = ptr_dec;
            end else if (ptr_ff == count_ff) begin
               found = 1'b1;
               x_w   = count_ff;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff[AW-1:0];
               ptr_in      = ptr_ff + CW'(1);
               chk_in      = 1'b1;
            end
            if (found) begin
               pos_in = x_w;
               if (x_w >= limit) begin
                  res_in           = '0;
                  res_in.status    = STATUS_REJECT;
                  res_in.row_count = count_ff[7:0];
                  state_in         = S_FINISH;
               end else begin
                  ptr_in   = count_ff;
                  chk_in   = 1'b0;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            if (chk_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = waddr_ff;
               ram_wr_data = ram_rd_data;
            end
            if (ptr_ff > pos_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_dec[AW-1:0];
               waddr_in    = ptr_ff[AW-1:0];
               ptr_in      = ptr_dec;
               chk_in      = 1'b1;
            end else begin
               chk_in = 1'b0;
               if (!chk_ff) begin
                  state_in = S_INSERT;
               end
            end
         end
         S_INSERT: begin
            ram_wr_en        = 1'b1;
            ram_wr_addr      = pos_ff[AW-1:0];
            ram_wr_data      = {req_ff.score, req_ff.payload};
            count_in         = count_ff + CW'(1);
            res_in           = '0;
            res_in.status    = STATUS_DONE;
            res_in.position  = pos_ff[7:0];
            res_in.row_count = count_in[7:0];
            state_in         = S_FINISH;
         end
         S_RDWAIT: begin
            res_in             = '0;
            res_in.status      = STATUS_DONE;
            res_in.row_score   = rd_entry.score;
            res_in.row_payload = rd_entry.payload;
            res_in.row_count   = count_ff[7:0];
            state_in           = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= MAX_ENTRIES_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      waddr_ff    <= waddr_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: hw/rtl/bstt_checker.sv
// ----------------------------------------------------------------------------
// bstt_checker
// port-level checks of the bounded sorted top-k table
// ----------------------------------------------------------------------------
module bstt_checker
   import bstt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a held response beat keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request in flight at a time
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_DONE) || (rsp_data.status == STATUS_REJECT)
                    || (rsp_data.status == STATUS_RANGE))
      else $error("bad status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_DONE)
      |-> (rsp_data.position == 8'd0) && (rsp_data.row_score == 32'd0)
          && (rsp_data.row_payload == 32'd0))
      else $error("failed beat carries nonzero fields");

endmodule

bind bounded_sorted_topk_table_unit bstt_checker u_bstt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
